[rtl/trie_keyword_matcher_core_assert.svh]
// Assertion macros used by the trie matcher core
`ifndef TRIE_KEYWORD_MATCHER_CORE_ASSERT_SVH
`define TRIE_KEYWORD_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define TKM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trie matcher check failed");

// Next-cycle implication, disabled while in reset
`define TKM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trie matcher check failed");

`endif

[rtl/tkm_pkg.sv]
package tkm_pkg;

  // Default sizing
  localparam int NODES_DEF        = 256;
  localparam int PAYLOAD_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MATCH   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_NO_MATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PARTIAL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd4;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_RESOLVE
  } state_t;

  // Write controls broadcast to the node cells
  typedef struct packed {
    logic alloc;   // new node: take link, payload flag and payload
    logic set_pl;  // existing node: set payload flag and payload
    logic has;     // payload flag written on allocation
  } cell_wr_t;

endpackage

[rtl/tkm_cell.sv]
module tkm_cell #(
  parameter int IDX          = 1,
  parameter int NODES        = tkm_pkg::NODES_DEF,
  parameter int PAYLOAD_BITS = tkm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              lookup_en,
  input  logic [$clog2(NODES)-1:0]          q_parent,
  input  logic [tkm_pkg::CHAR_W-1:0]        q_char,
  input  logic [$clog2(NODES+1)-1:0]        nodes_used,
  input  tkm_pkg::cell_wr_t                 wr,
  input  logic [$clog2(NODES)-1:0]          wr_idx,
  input  logic [$clog2(NODES)-1:0]          wr_parent,
  input  logic [tkm_pkg::CHAR_W-1:0]        wr_char,
  input  logic [PAYLOAD_BITS-1:0]           wr_payload,
  output logic                              hit,
  output logic                              hit_has,
  output logic [PAYLOAD_BITS-1:0]           hit_payload
);
  import tkm_pkg::*;

  localparam int IW  = $clog2(NODES);
  localparam int NUW = $clog2(NODES+1);
  localparam logic [IW-1:0]  MY_IDX = IW'(IDX);
  localparam logic [NUW-1:0] MY_CNT = NUW'(IDX);

  logic [IW-1:0]           parent_r;
  logic [CHAR_W-1:0]       char_r;
  logic                    has_r;
  logic [PAYLOAD_BITS-1:0] payload_r;
  logic                    hit_r;
  logic                    hit_nxt;
  logic                    sel;

  // Node is live once allocated
  assign hit_nxt = (MY_CNT < nodes_used) && (parent_r == q_parent) && (char_r == q_char);
  assign sel     = (wr_idx == MY_IDX);

  // Compare stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (lookup_en) begin
      hit_r <= hit_nxt;
    end
  end

  // Node contents, written on allocation or payload store
  always_ff @(posedge clk) begin
    if (sel && wr.alloc) begin
      parent_r  <= wr_parent;
      char_r    <= wr_char;
      has_r     <= wr.has;
      payload_r <= wr_payload;
    end else if (sel && wr.set_pl) begin
      has_r     <= 1'b1;
      payload_r <= wr_payload;
    end
  end

  // Contributions are zero unless this node hit
  assign hit         = hit_r;
  assign hit_has     = hit_r & has_r;
  assign hit_payload = hit_r ? payload_r : '0;

endmodule

[rtl/tkm_cell_array.sv]
module tkm_cell_array #(
  parameter int NODES        = tkm_pkg::NODES_DEF,
  parameter int PAYLOAD_BITS = tkm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              lookup_en,
  input  logic [$clog2(NODES)-1:0]          q_parent,
  input  logic [tkm_pkg::CHAR_W-1:0]        q_char,
  input  logic [$clog2(NODES+1)-1:0]        nodes_used,
  input  tkm_pkg::cell_wr_t                 wr,
  input  logic [$clog2(NODES)-1:0]          wr_idx,
  input  logic [$clog2(NODES)-1:0]          wr_parent,
  input  logic [tkm_pkg::CHAR_W-1:0]        wr_char,
  input  logic [PAYLOAD_BITS-1:0]           wr_payload,
  output logic                              found,
  output logic [$clog2(NODES)-1:0]          found_idx,
  output logic                              found_has,
  output logic [PAYLOAD_BITS-1:0]           found_payload
);
  import tkm_pkg::*;

  localparam int IW = $clog2(NODES);

  logic [NODES-1:0]        hit_v;
  logic [NODES-1:0]        has_v;
  logic [PAYLOAD_BITS-1:0] pl_v [NODES];

  // The root is never a child
  assign hit_v[0] = 1'b0;
  assign has_v[0] = 1'b0;
  assign pl_v[0]  = '0;

  // One cell per non-root node
  for (genvar i = 1; i < NODES; i++) begin : g_cell
    tkm_cell #(
      .IDX          (i),
      .NODES        (NODES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .lookup_en   (lookup_en),
      .q_parent    (q_parent),
      .q_char      (q_char),
      .nodes_used  (nodes_used),
      .wr          (wr),
      .wr_idx      (wr_idx),
      .wr_parent   (wr_parent),
      .wr_char     (wr_char),
      .wr_payload  (wr_payload),
      .hit         (hit_v[i]),
      .hit_has     (has_v[i]),
      .hit_payload (pl_v[i])
    );
  end

  // At most one cell hits: OR the registered contributions together
  always_comb begin
    found         = 1'b0;
    found_idx     = '0;
    found_has     = 1'b0;
    found_payload = '0;
    for (int i = 0; i < NODES; i++) begin
      found         = found | hit_v[i];
      found_idx     = found_idx | (hit_v[i] ? IW'(i) : '0);
      found_has     = found_has | has_v[i];
      found_payload = found_payload | pl_v[i];
    end
  end

endmodule

[rtl/trie_keyword_matcher_core.sv]
// An input transfer loads the item registers; in the compare step every node
// cell checks parent and byte and registers its hit, then the resolve step
// merges the cell hits, commits the trie update and loads the output register.
// Output stalls hold the resolve step; the next item is taken as it commits.
// Reset (rst_n, synchronous, active low): cursors to the root, node count to
// one, blocked flag and output valid cleared; node cells are written on alloc.
module trie_keyword_matcher_core #(
  parameter int NODES        = tkm_pkg::NODES_DEF,
  parameter int PAYLOAD_BITS = tkm_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tkm_pkg::CMD_W-1:0]        in_command,
  input  logic [tkm_pkg::CHAR_W-1:0]       in_character,
  input  logic                             in_last,
  input  logic [tkm_pkg::VALUE_W-1:0]      in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tkm_pkg::STATUS_W-1:0]     out_status,
  output logic [tkm_pkg::VALUE_W-1:0]      out_result_value
);
  import tkm_pkg::*;

  `include "trie_keyword_matcher_core_assert.svh"

  localparam int IW  = $clog2(NODES);
  localparam int NUW = $clog2(NODES+1);

  state_t state_r, state_nxt;

  // Item registers
  logic [CMD_W-1:0]   cmd_r;
  logic [CHAR_W-1:0]  char_r;
  logic               last_r;
  logic [VALUE_W-1:0] value_r;

  // Trie control state
  logic [NUW-1:0] nodes_used_r, nodes_used_nxt;
  logic [IW-1:0]  icur_r, icur_nxt;
  logic [IW-1:0]  mcur_r, mcur_nxt;
  logic           blocked_r, blocked_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, status_nxt;
  logic [VALUE_W-1:0]  out_value_r, res_nxt;

  logic in_xfer;
  logic can_load;
  logic lookup_en;
  logic commit;

  // Cell array interface
  logic                    found;
  logic [IW-1:0]           found_idx;
  logic                    found_has;
  logic [PAYLOAD_BITS-1:0] found_payload;
  logic [IW-1:0]           q_parent;
  cell_wr_t                wr;
  logic [IW-1:0]           wr_idx;
  logic [PAYLOAD_BITS-1:0] pl_in;
  logic [63:0]             val64;
  logic [63:0]             fp64;
  logic                    full;

  assign in_xfer  = in_valid & in_ready;
  assign can_load = ~out_valid_r | out_ready;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_LOOKUP;
      S_LOOKUP:  state_nxt = S_RESOLVE;
      S_RESOLVE: if (can_load) state_nxt = in_valid ? S_LOOKUP : S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    lookup_en = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      S_IDLE:    in_ready = 1'b1;
      S_LOOKUP:  lookup_en = 1'b1;
      S_RESOLVE: begin
        in_ready = can_load;
        commit   = can_load;
      end
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_command;
      char_r  <= in_character;
      last_r  <= in_last;
      value_r <= in_value;
    end
  end

  assign q_parent = (cmd_r == CMD_INSERT) ? icur_r : mcur_r;
  assign val64    = 64'(value_r);
  assign pl_in    = val64[PAYLOAD_BITS-1:0];
  assign fp64     = 64'(found_payload);
  assign full     = (nodes_used_r == NUW'(NODES));

  tkm_cell_array #(
    .NODES        (NODES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_array (
    .clk           (clk),
    .rst_n         (rst_n),
    .lookup_en     (lookup_en),
    .q_parent      (q_parent),
    .q_char        (char_r),
    .nodes_used    (nodes_used_r),
    .wr            (wr),
    .wr_idx        (wr_idx),
    .wr_parent     (icur_r),
    .wr_char       (char_r),
    .wr_payload    (pl_in),
    .found         (found),
    .found_idx     (found_idx),
    .found_has     (found_has),
    .found_payload (found_payload)
  );

  // Resolve: work out the result and the trie update
  always_comb begin
    nodes_used_nxt = nodes_used_r;
    icur_nxt       = icur_r;
    mcur_nxt       = mcur_r;
    blocked_nxt    = blocked_r;
    status_nxt     = ST_DONE;
    res_nxt        = '0;
    wr             = '0;
    wr_idx         = found_idx;
    case (cmd_r)
      CMD_INSERT: begin
        if (blocked_r) begin
          status_nxt = ST_TABLE_FULL;
          if (last_r) begin
            blocked_nxt = 1'b0;
            icur_nxt    = '0;
          end
        end else if (found) begin
          if (last_r) begin
            wr.set_pl = commit;
            icur_nxt  = '0;
          end else begin
            icur_nxt = found_idx;
          end
        end else if (full) begin
          status_nxt = ST_TABLE_FULL;
          if (last_r) begin
            icur_nxt = '0;
          end else begin
            blocked_nxt = 1'b1;
          end
        end else begin
          // Allocate the next free node
          wr.alloc       = commit;
          wr.has         = last_r;
          wr_idx         = nodes_used_r[IW-1:0];
          nodes_used_nxt = nodes_used_r + NUW'(1);
          icur_nxt       = last_r ? '0 : nodes_used_r[IW-1:0];
        end
      end
      CMD_MATCH: begin
        if (found) begin
          mcur_nxt = found_idx;
          if (found_has) begin
            status_nxt = ST_FULL;
            res_nxt    = fp64[VALUE_W-1:0];
          end else begin
            status_nxt = ST_PARTIAL;
          end
        end else begin
          status_nxt = ST_NO_MATCH;
        end
      end
      CMD_RESTART: mcur_nxt = '0;
      default:     status_nxt = ST_DONE;
    endcase
  end

  // Trie control registers, updated on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_used_r <= NUW'(1);
      icur_r       <= '0;
      mcur_r       <= '0;
      blocked_r    <= 1'b0;
    end else if (commit) begin
      nodes_used_r <= nodes_used_nxt;
      icur_r       <= icur_nxt;
      mcur_r       <= mcur_nxt;
      blocked_r    <= blocked_nxt;
    end
  end

  // Output register
  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= status_nxt;
      out_value_r  <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

  // Checks
  `TKM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, nodes_used_r <= NUW'(NODES))
  `TKM_ASSERT_NOW(a_blocked_full, clk, rst_n, blocked_r, nodes_used_r == NUW'(NODES))
  `TKM_ASSERT_NXT(a_xfer_lookup, clk, rst_n, in_xfer, state_r == S_LOOKUP)
  `TKM_ASSERT_NOW(a_out_from_resolve, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_RESOLVE)

endmodule
